// ===== hdl/tfd_pkg.sv =====
// shared types and constants for the telemetry frame deframer
// no dependencies; imported by every module of the block
package tfd_pkg;

    localparam int unsigned BYTE_W = 8;

    // frame byte positions
    localparam logic [3:0] POS_HDR_FIRST   = 4'd0;
    localparam logic [3:0] POS_HDR_SECOND  = 4'd1;
    localparam logic [3:0] POS_CRC_FIRST   = 4'd2;
    localparam logic [3:0] POS_FIELD_FIRST = 4'd5;
    localparam logic [3:0] POS_CRC_LAST    = 4'd12;
    localparam logic [3:0] POS_FRAME_LAST  = 4'd13;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    typedef enum logic [0:0] {
        CFG_SYNC_FIRST  = 1'b0,
        CFG_SYNC_SECOND = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_DATA  = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] pos;
        logic [7:0] data;
    } q_entry_t;

endpackage

// ===== hdl/telemetry_frame_deframer.sv =====
// top level of the telemetry frame deframer
// depends on tfd_pkg, tfd_front, tfd_queue and tfd_back
//
// Takes one received word per cycle (s_rx_byte, or an idle break that aborts
// a partial frame), hunts for the two sync bytes held in registers 0 and 1 and
// delivers one telemetry result per 14-byte frame, with frame_status 1 when the
// crc-8 (poly 0x07, init 0) over bytes 2..12 does not match byte 13. Input words
// are taken back to back at one per cycle while s_ready is high; the front end
// keeps the byte count, a QUEUE_DEPTH-word queue carries frame body and frame
// end words to the back end, which runs the crc one byte per cycle. A frame's
// last byte goes through the queue, and its result then sits in an output
// register. Only a frame end word can wait in the back end, and only while the
// previous result is still held by m_ready low; meanwhile the queue fills with
// the body words that follow and s_ready drops until the result is taken.
module telemetry_frame_deframer
    import tfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_idle_break,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_status,
    output logic [7:0]  m_sequence_number,
    output logic [7:0]  m_motor_state,
    output logic [7:0]  m_commanded_duty,
    output logic [7:0]  m_target_duty_value,
    output logic [7:0]  m_present_duty,
    output logic [7:0]  m_emergency_stop,
    output logic [15:0] m_adc_reading
);

    logic     push_valid, q_full, pop_valid, pop_ready;
    q_entry_t push_entry, pop_entry;

    tfd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_idle_break (s_idle_break),
        .push_valid   (push_valid),
        .push_entry   (push_entry),
        .q_full       (q_full)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    tfd_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (pop_valid),
        .in_entry            (pop_entry),
        .in_ready            (pop_ready),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_status      (m_frame_status),
        .m_sequence_number   (m_sequence_number),
        .m_motor_state       (m_motor_state),
        .m_commanded_duty    (m_commanded_duty),
        .m_target_duty_value (m_target_duty_value),
        .m_present_duty      (m_present_duty),
        .m_emergency_stop    (m_emergency_stop),
        .m_adc_reading       (m_adc_reading)
    );

endmodule

// ===== hdl/tfd_front.sv =====
// front end: sync register file, header hunt and byte position counter
// depends on tfd_pkg; pushes frame body and frame end words into the queue
module tfd_front
    import tfd_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [0:0]     cfg_addr,
    input  logic [7:0]     cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_rx_byte,
    input  logic           s_idle_break,
    output logic           push_valid,
    output q_entry_t       push_entry,
    input  logic           q_full
);

    logic [7:0] sync_first_reg, sync_second_reg;
    logic [3:0] pos_reg, pos_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        push_valid = 1'b0;
        push_entry.op   = OP_DATA;
        push_entry.pos  = pos_reg;
        push_entry.data = s_rx_byte;
        if (accept) begin
            if (s_idle_break) begin
                pos_next = POS_HDR_FIRST;
            end else begin
                case (pos_reg) inside
                    POS_HDR_FIRST: begin
                        if (s_rx_byte == sync_first_reg) pos_next = POS_HDR_SECOND;
                    end
                    POS_HDR_SECOND: begin
                        if (s_rx_byte == sync_second_reg) begin
                            pos_next = POS_CRC_FIRST;
                        end else if (s_rx_byte == sync_first_reg) begin
                            pos_next = POS_HDR_SECOND;
                        end else begin
                            pos_next = POS_HDR_FIRST;
                        end
                    end
                    [POS_CRC_FIRST:POS_CRC_LAST]: begin
                        push_valid = 1'b1;
                        pos_next   = pos_reg + 4'd1;
                    end
                    POS_FRAME_LAST: begin
                        push_valid    = 1'b1;
                        push_entry.op = OP_CHECK;
                        pos_next      = POS_HDR_FIRST;
                    end
                    default: pos_next = POS_HDR_FIRST;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HDR_FIRST;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hdl/tfd_queue.sv =====
// small word queue between front end and back end
// depends on tfd_pkg for the entry type
module tfd_queue
    import tfd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  q_entry_t push_entry,
    output logic     full,
    output logic     pop_valid,
    output q_entry_t pop_entry,
    input  logic     pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + CNT_W'(1);
        if (!do_push && do_pop) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_valid && full))
        else $error("word pushed into full queue");

    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count lost a push");

    a_ptr_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hdl/tfd_back.sv =====
// back end: crc-8 over the frame body, field capture and result register
// depends on tfd_pkg; takes words from tfd_queue
module tfd_back
    import tfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  q_entry_t    in_entry,
    output logic        in_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_status,
    output logic [7:0]  m_sequence_number,
    output logic [7:0]  m_motor_state,
    output logic [7:0]  m_commanded_duty,
    output logic [7:0]  m_target_duty_value,
    output logic [7:0]  m_present_duty,
    output logic [7:0]  m_emergency_stop,
    output logic [15:0] m_adc_reading
);

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = ((c & CRC_MSB) != '0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [7:0] crc_reg, crc_base;
    logic [7:0] fld_reg [8];
    logic       m_valid_reg;
    logic       out_free, take, is_check;
    logic       status_reg;
    logic [7:0] seq_reg, mstate_reg, cmd_reg, tgt_reg, cur_reg, estop_reg;
    logic [15:0] adc_reg;
    logic [2:0] fld_idx;

    assign is_check = (in_entry.op == OP_CHECK);
    assign out_free = !m_valid_reg || m_ready;
    // body words never wait on the result register
    assign in_ready = !is_check || out_free;
    assign take     = in_valid && in_ready;
    assign crc_base = (in_entry.pos == POS_CRC_FIRST) ? '0 : crc_reg;
    assign fld_idx  = 3'(in_entry.pos - POS_FIELD_FIRST);

    always_ff @(posedge aclk) begin
        if (take && !is_check) begin
            crc_reg <= crc_step(crc_base, in_entry.data);
            if (in_entry.pos >= POS_FIELD_FIRST) fld_reg[fld_idx] <= in_entry.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && is_check) begin
            status_reg <= (crc_reg != in_entry.data);
            seq_reg    <= fld_reg[0];
            mstate_reg <= fld_reg[1];
            cmd_reg    <= fld_reg[2];
            tgt_reg    <= fld_reg[3];
            cur_reg    <= fld_reg[4];
            estop_reg  <= fld_reg[5];
            adc_reg    <= {fld_reg[7], fld_reg[6]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take && is_check) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_frame_status      = status_reg;
    assign m_sequence_number   = seq_reg;
    assign m_motor_state       = mstate_reg;
    assign m_commanded_duty    = cmd_reg;
    assign m_target_duty_value = tgt_reg;
    assign m_present_duty      = cur_reg;
    assign m_emergency_stop    = estop_reg;
    assign m_adc_reading       = adc_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(take && is_check))
        else $error("frame result overwrote a pending result");

    a_body_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !is_check) |-> in_ready)
        else $error("body word stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && is_check) |=> m_valid_reg)
        else $error("frame end word produced no result");

endmodule
